[hdl/dua_pkg.sv]
// dua_pkg: shared types, constants and saturating helpers for the disk usage accumulator
// no dependencies; imported by every module of the block except dua_ram

package dua_pkg;

  localparam int unsigned OWNER_ENTRIES = 1024;
  localparam int unsigned SIZE_BINS     = 512;

  localparam int unsigned OWNER_AW = $clog2(OWNER_ENTRIES);
  localparam int unsigned BIN_AW   = $clog2(SIZE_BINS);
  localparam int unsigned CLR_LEN  = (OWNER_ENTRIES > SIZE_BINS) ? OWNER_ENTRIES : SIZE_BINS;
  localparam int unsigned CLR_AW   = $clog2(CLR_LEN);

  localparam int unsigned KB_W   = 23;
  localparam int unsigned PROD_W = 26;

  localparam logic [3:0] TYPE_FREE = 4'h0;
  localparam logic [3:0] TYPE_DIR  = 4'h4;
  localparam logic [3:0] TYPE_REG  = 4'h8;

  typedef enum logic [1:0] {
    CMD_ACCOUNT = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] file_mode;
    logic [31:0] size_bytes;
    logic [15:0] owner_id;
    logic [9:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] entry_count;
    logic [31:0] amount_kbytes;
    logic        is_last_bin;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic load_out;
    logic clr_wr;
    logic clr_start;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
  } dp_status_t;

  function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [15:0] inc_sat16(input logic [15:0] a);
    return (&a) ? a : a + 16'd1;
  endfunction

endpackage

[hdl/disk_usage_accumulator.sv]
// disk_usage_accumulator: top level, per-owner disk usage and file-size histogram
// depends on dua_pkg, dua_ctrl, dua_dpath and dua_ram

// An account or read request is accepted in a cycle that reads the owner and size-bin
// memories; the next cycle writes the updated entry back or loads the result register, and
// the block takes the next request in the cycle after that. A read whose result cannot enter
// the output register because the previous result is still stalled waits in the update state.
// After reset and after each clear request, a clearing pass zeroes both tables, one address
// a cycle over max(OWNER_ENTRIES, SIZE_BINS) addresses, 1024 as built, with stall high; the
// mode register can be written at any time the block is idle and has no ordering with it.

module disk_usage_accumulator import dua_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  dua_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.command),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  dua_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

endmodule

[hdl/dua_ram.sv]
// dua_ram: generic single write port, single read port ram with registered read data
// no dependencies

module dua_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/dua_ctrl.sv]
// dua_ctrl: sequencer for request acceptance, table update, result handoff and clearing
// depends on dua_pkg

module dua_ctrl import dua_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e    state_q, state_d;
  logic      is_read_q, is_read_d;
  logic      out_valid_q, out_valid_d;
  ctrl_cmd_t cmd;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    is_read_d = is_read_q;
    cmd       = '0;
    case (state_q)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          case (in_cmd_i)
            CMD_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_d       = S_CLEAR;
            end
            CMD_ACCOUNT: begin
              is_read_d = 1'b0;
              state_d   = S_UPDATE;
            end
            CMD_READ: begin
              is_read_d = 1'b1;
              state_d   = S_UPDATE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_UPDATE: begin
        if (!is_read_q || out_free) begin
          cmd.update   = 1'b1;
          cmd.load_out = is_read_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
    out_valid_d = cmd.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_read_q   <= is_read_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

[hdl/dua_dpath.sv]
// dua_dpath: mode register, owner and size-bin tables, sums, read-out and output register
// depends on dua_pkg and dua_ram

module dua_dpath import dua_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  output logic       cfg_ready_o,
  input  in_item_t   in_data_i,
  input  ctrl_cmd_t  cmd_i,
  output out_item_t  out_data_o,
  output dp_status_t status_o
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // kilobytes rounded up and target bin of the incoming request
  logic [KB_W-1:0]   kb_in;
  logic [BIN_AW-1:0] bin_in;
  logic              in_is_read;

  assign kb_in      = {1'b0, in_data_i.size_bytes[31:10]} + KB_W'(|in_data_i.size_bytes[9:0]);
  assign bin_in     = (32'(kb_in) >= 32'(SIZE_BINS)) ? BIN_AW'(SIZE_BINS - 1) : BIN_AW'(kb_in);
  assign in_is_read = (in_data_i.command == CMD_READ);

  logic [1:0]        cmd_q;
  logic [KB_W-1:0]   kb_q;
  logic [3:0]        type_q;
  logic [15:0]       owner_q;
  logic [9:0]        idx_q;
  logic [BIN_AW-1:0] bin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q   <= in_data_i.command;
      kb_q    <= kb_in;
      type_q  <= in_data_i.file_mode[15:12];
      owner_q <= in_data_i.owner_id;
      idx_q   <= in_data_i.entry_index;
      bin_q   <= bin_in;
    end
  end

  // clearing sweep
  logic [CLR_AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_start) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= status_o.clr_done ? '0 : clr_cnt_q + CLR_AW'(1);
    end
  end

  assign status_o.clr_done = (32'(clr_cnt_q) == 32'(CLR_LEN - 1));

  // tables
  logic              own_we, bin_we;
  logic [OWNER_AW-1:0] own_waddr, own_raddr;
  logic [BIN_AW-1:0] bin_waddr, bin_raddr;
  logic [47:0]       own_wdata, own_rdata;
  logic [15:0]       bin_wdata, bin_rdata;

  assign own_raddr = in_is_read ? OWNER_AW'(in_data_i.entry_index)
                                : OWNER_AW'(in_data_i.owner_id);
  assign bin_raddr = in_is_read ? BIN_AW'(in_data_i.entry_index) : bin_in;

  dua_ram #(.WIDTH(48), .DEPTH(OWNER_ENTRIES)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (own_we),
    .waddr_i (own_waddr),
    .wdata_i (own_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (own_raddr),
    .rdata_o (own_rdata)
  );

  dua_ram #(.WIDTH(16), .DEPTH(SIZE_BINS)) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  // accounting update
  logic acct, own_acct, bin_acct, ovf_hit;

  assign acct     = cmd_i.update && (cmd_q == CMD_ACCOUNT) && (type_q != TYPE_FREE);
  assign own_acct = acct && !mode_q && (32'(owner_q) < 32'(OWNER_ENTRIES));
  assign bin_acct = acct && mode_q && ((type_q == TYPE_DIR) || (type_q == TYPE_REG));
  assign ovf_hit  = bin_acct && (32'(kb_q) >= 32'(SIZE_BINS));

  assign own_we    = (cmd_i.clr_wr && (32'(clr_cnt_q) < 32'(OWNER_ENTRIES))) || own_acct;
  assign own_waddr = cmd_i.clr_wr ? OWNER_AW'(clr_cnt_q) : OWNER_AW'(owner_q);
  assign own_wdata = cmd_i.clr_wr ? 48'd0
                   : {add_sat32(own_rdata[47:16], 32'(kb_q)), inc_sat16(own_rdata[15:0])};

  assign bin_we    = (cmd_i.clr_wr && (32'(clr_cnt_q) < 32'(SIZE_BINS))) || bin_acct;
  assign bin_waddr = cmd_i.clr_wr ? BIN_AW'(clr_cnt_q) : bin_q;
  assign bin_wdata = cmd_i.clr_wr ? 16'd0 : inc_sat16(bin_rdata);

  // read-out
  logic [31:0]       ovf_q, total_q;
  logic [PROD_W-1:0] prod;
  logic [31:0]       hist_sum;
  logic              total_upd;
  out_item_t         out_d, out_q;

  assign prod     = PROD_W'(idx_q) * PROD_W'(bin_rdata);
  assign hist_sum = add_sat32((idx_q == 10'd0) ? 32'd0 : total_q, 32'(prod));

  always_comb begin
    out_d     = '0;
    total_upd = 1'b0;
    if (mode_q) begin
      if (32'(idx_q) < 32'(SIZE_BINS - 1)) begin
        out_d.entry_count   = bin_rdata;
        out_d.amount_kbytes = hist_sum;
        total_upd           = 1'b1;
      end else if (32'(idx_q) == 32'(SIZE_BINS - 1)) begin
        out_d.entry_count   = bin_rdata;
        out_d.amount_kbytes = add_sat32(total_q, ovf_q);
        out_d.is_last_bin   = 1'b1;
      end
    end else if (32'(idx_q) < 32'(OWNER_ENTRIES)) begin
      out_d.entry_count   = own_rdata[15:0];
      out_d.amount_kbytes = own_rdata[47:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q   <= '0;
      total_q <= '0;
    end else if (cmd_i.clr_start) begin
      ovf_q   <= '0;
      total_q <= '0;
    end else begin
      if (ovf_hit) begin
        ovf_q <= add_sat32(ovf_q, 32'(kb_q));
      end
      if (cmd_i.load_out && total_upd) begin
        total_q <= hist_sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

[hdl/dua_checker.sv]
// dua_checker: port-level assertions for the disk usage accumulator, bound to the top level
// depends on dua_pkg and disk_usage_accumulator

module dua_checker import dua_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((in_data_i.command == CMD_ACCOUNT) || (in_data_i.command == CMD_READ) ||
               (in_data_i.command == CMD_CLEAR)) |=> in_stall_o)
    else $error("request accepted in back-to-back cycles");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.command != CMD_READ) && !out_valid_o |=> !out_valid_o ##1 !out_valid_o)
    else $error("result produced for a non-read request");

  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.command == CMD_CLEAR) |=> in_stall_o ##1 in_stall_o)
    else $error("request accepted during clearing pass");

endmodule

bind disk_usage_accumulator dua_checker u_dua_checker (.*);
